### rtl/wpac_pkg.sv
`timescale 1ns / 1ps

package wpac_pkg;

  // Number of register stages from the input capture to the output register.
  localparam int NumStg = 7;

  // Field widths.
  localparam int LatW  = 31;
  localparam int LngW  = 32;
  localparam int ThrW  = 16;
  localparam int CfgW  = 32;

  // Magnitudes of the latitude and longitude differences, and the mean latitude.
  localparam int AW    = LatW + 1;
  localparam int BW    = LngW + 1;
  localparam int MeanW = LatW;

  // Cosine samples are Q1.15 and never exceed 32767.
  localparam int CosW  = 15;

  // Units of 1e-7 degree in one quarter turn.
  localparam longint QuarterTurn = 64'd900000000;

  // One stage enable per pipeline register, bit k for stage k.
  typedef logic [NumStg-1:0] stg_vec_t;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CfgTargetLat   = 2'd0,
    CfgTargetLng   = 2'd1,
    CfgTargetValid = 2'd2,
    CfgArrivalThr  = 2'd3
  } cfg_idx_e;

  // Result codes.
  typedef enum logic [3:0] {
    DirN        = 4'd0,
    DirNE       = 4'd1,
    DirE        = 4'd2,
    DirSE       = 4'd3,
    DirS        = 4'd4,
    DirSW       = 4'd5,
    DirW        = 4'd6,
    DirNW       = 4'd7,
    DirArrived  = 4'd8,
    DirNoTarget = 4'd9
  } dir_e;

endpackage

### rtl/wpac_cos_idx.sv
`timescale 1ns / 1ps

// Cosine table index from the mean latitude:
// floor(mean * depth / quarter turn), saturated at the last entry.
// Stage 1 multiplies by a reciprocal, stage 2 corrects by one and saturates.
module wpac_cos_idx import wpac_pkg::*; #(
  parameter int unsigned COS_TABLE_DEPTH = 1024,
  localparam int IdxW = $clog2(COS_TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  stg_vec_t         en_i,
  input  logic [MeanW-1:0] mean_i,
  output logic [IdxW-1:0]  idx_o
);

  localparam int     ShiftS = 31;
  localparam longint RecipK = ((longint'(1) << ShiftS) * COS_TABLE_DEPTH) / QuarterTurn;
  localparam int     KW     = $clog2(RecipK + 1);
  localparam int     DW     = $clog2(COS_TABLE_DEPTH + 1);
  localparam longint QMax   = ((longint'(1) << 30) * COS_TABLE_DEPTH) / QuarterTurn;
  localparam int     QW     = $clog2(QMax + 2);
  localparam int     MkW    = MeanW + KW;
  localparam int     MdW    = MeanW + DW;
  localparam int     CmpW   = MdW + 1;

  logic [MkW-1:0]  mk_q;
  logic [MdW-1:0]  md_q;
  logic [QW-1:0]   q0;
  logic [QW-1:0]   q1;
  logic [QW-1:0]   qc;
  logic [CmpW-1:0] prod;
  logic [IdxW-1:0] idx_q;

  // Reciprocal estimate and exact numerator.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mk_q <= MkW'(mean_i) * MkW'(RecipK);
      md_q <= MdW'(mean_i) * MdW'(COS_TABLE_DEPTH);
    end
  end

  // The estimate is the true quotient or one below it.
  always_comb begin
    q0   = QW'(mk_q >> ShiftS);
    q1   = q0 + QW'(1);
    prod = CmpW'(q1) * CmpW'(QuarterTurn);
    qc   = (CmpW'(md_q) >= prod) ? q1 : q0;
  end

  // Saturate past the pole.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      if (qc >= QW'(COS_TABLE_DEPTH)) begin
        idx_q <= IdxW'(COS_TABLE_DEPTH - 1);
      end else begin
        idx_q <= IdxW'(qc);
      end
    end
  end

  assign idx_o = idx_q;

endmodule

### rtl/wpac_cos_lut.sv
`timescale 1ns / 1ps

// Constant cosine ROM, entry i = cos(i * 90 / depth degrees) in Q1.15,
// built at elaboration from a seven-term series. The read data is registered.
module wpac_cos_lut import wpac_pkg::*; #(
  parameter int unsigned COS_TABLE_DEPTH = 1024,
  localparam int IdxW = $clog2(COS_TABLE_DEPTH)
) (
  input  logic            clk_i,
  input  stg_vec_t        en_i,
  input  logic [IdxW-1:0] idx_i,
  output logic [CosW-1:0] cos_o
);

  localparam longint HalfPiQ30 = 64'd1686629713;
  localparam longint OneQ30    = 64'd1073741824;

  // Nested series 1 - a^2/2 (1 - a^2/12 (1 - ...)), clamped at zero per step.
  function automatic logic [CosW-1:0] cos_q15(input longint ang);
    longint a2;
    longint t;
    longint q;
    a2 = (ang * ang) >>> 30;
    t  = OneQ30;
    t  = OneQ30 - ((a2 * t) >>> 30) / 132;
    if (t < 0) t = 0;
    t  = OneQ30 - ((a2 * t) >>> 30) / 90;
    if (t < 0) t = 0;
    t  = OneQ30 - ((a2 * t) >>> 30) / 56;
    if (t < 0) t = 0;
    t  = OneQ30 - ((a2 * t) >>> 30) / 30;
    if (t < 0) t = 0;
    t  = OneQ30 - ((a2 * t) >>> 30) / 12;
    if (t < 0) t = 0;
    t  = OneQ30 - ((a2 * t) >>> 30) / 2;
    if (t < 0) t = 0;
    q  = (t + 64'sd16384) >>> 15;
    if (q > 32767) q = 32767;
    return q[CosW-1:0];
  endfunction

  logic [CosW-1:0] rom [COS_TABLE_DEPTH];
  logic [CosW-1:0] cos_q;

  for (genvar i = 0; i < COS_TABLE_DEPTH; i++) begin : g_rom
    localparam longint Ang = (longint'(i) * HalfPiQ30) / COS_TABLE_DEPTH;
    assign rom[i] = cos_q15(Ang);
  end

  // Registered read.
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      cos_q <= rom[idx_i];
    end
  end

  assign cos_o = cos_q;

endmodule

### rtl/wpac_octant.sv
`timescale 1ns / 1ps

// Compass octant of the raw differences. Stage 1 scales both magnitudes
// below 2^31, stage 2 forms the squares, stage 3 compares against tan 22.5
// through (a+b)^2 < 2a^2, stages 4 and 5 align the code with the distance path.
module wpac_octant import wpac_pkg::*; (
  input  logic          clk_i,
  input  stg_vec_t      en_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  input  logic          lat_pos_i,
  input  logic          lng_pos_i,
  output dir_e          code_o
);

  logic [30:0] sa_d;
  logic [30:0] sb_d;
  logic [30:0] sa_q;
  logic [30:0] sb_q;
  logic [2:1]  latp_q;
  logic [2:1]  lngp_q;
  logic [2:1]  zero_q;
  logic [31:0] sum_ab;
  logic [63:0] ss_q;
  logic [61:0] sqa_q;
  logic [61:0] sqb_q;
  dir_e        code_d;
  dir_e        code3_q;
  dir_e        code4_q;
  dir_e        code5_q;

  // Halve both until each is below 2^31; at most two halvings are needed.
  always_comb begin
    if (b_i[BW-1]) begin
      sa_d = 31'(a_i >> 2);
      sb_d = 31'(b_i >> 2);
    end else if (b_i[BW-2] || a_i[AW-1]) begin
      sa_d = 31'(a_i >> 1);
      sb_d = 31'(b_i >> 1);
    end else begin
      sa_d = 31'(a_i);
      sb_d = 31'(b_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sa_q      <= sa_d;
      sb_q      <= sb_d;
      latp_q[1] <= lat_pos_i;
      lngp_q[1] <= lng_pos_i;
      zero_q[1] <= (a_i == '0) && (b_i == '0);
    end
  end

  // Squares.
  assign sum_ab = 32'(sa_q) + 32'(sb_q);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ss_q      <= 64'(sum_ab) * 64'(sum_ab);
      sqa_q     <= 62'(sa_q) * 62'(sa_q);
      sqb_q     <= 62'(sb_q) * 62'(sb_q);
      latp_q[2] <= latp_q[1];
      lngp_q[2] <= lngp_q[1];
      zero_q[2] <= zero_q[1];
    end
  end

  // Axis or diagonal, then the signs pick the octant. Equal points face north.
  always_comb begin
    if (zero_q[2]) begin
      code_d = DirN;
    end else if (ss_q < 64'({sqa_q, 1'b0})) begin
      code_d = latp_q[2] ? DirN : DirS;
    end else if (ss_q < 64'({sqb_q, 1'b0})) begin
      code_d = lngp_q[2] ? DirE : DirW;
    end else if (latp_q[2]) begin
      code_d = lngp_q[2] ? DirNE : DirNW;
    end else begin
      code_d = lngp_q[2] ? DirSE : DirSW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      code3_q <= code_d;
    end
    if (en_i[4]) begin
      code4_q <= code3_q;
    end
    if (en_i[5]) begin
      code5_q <= code4_q;
    end
  end

  assign code_o = code5_q;

endmodule

### rtl/waypoint_arrival_and_compass_octant.sv
`timescale 1ns / 1ps

// Waypoint arrival test and compass octant toward a target waypoint.
// A position fix enters on the s_axis channel (tdata: pos_lat in bits 30:0,
// pos_lng in bits 62:31, 1e-7 degree units, two's complement). For every fix
// exactly one direction code leaves on the m_axis channel: 0..7 for the
// octants N, NE, E, SE, S, SW, W, NW, 8 for arrived, 9 for no target.
// The target and the arrival radius are written through the cfg port
// (index 0 target_lat, 1 target_lng, 2 target_valid, 3 arrival_threshold);
// write them only while no fix is in flight.
// Throughput is one fix per cycle while the receiver keeps up; the seven register
// stages (differences, index multiply, index correction, cosine ROM read,
// scaled-distance multiply, squaring, final compare) each take one fix per cycle
// unless the output stalls.
// Reset empties the pipeline and loads target_valid = 0 and a radius of 10 m.
// The cosine table is a constant ROM and needs no fill time.
// When the receiver stalls, the stages hold their contents and empty stages
// keep filling; s_axis_tready falls only when all seven stages are full.
module waypoint_arrival_and_compass_octant import wpac_pkg::*; #(
  parameter int unsigned COS_TABLE_DEPTH = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Configuration writes.
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  // Position fixes.
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [63:0]     s_axis_tdata_i,   // pos_lat [30:0], pos_lng [62:31], zero [63]
  // Direction codes.
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o    // direction_code [3:0], zero [7:4]
);

  localparam int IdxW = $clog2(COS_TABLE_DEPTH);
  localparam int XpW  = BW + CosW;
  localparam int RW   = 31;
  localparam logic [CosW-1:0] UnitsPerMQ8 = 15'd23023;

  // Configuration registers.
  logic [LatW-1:0] tlat_q;
  logic [LngW-1:0] tlng_q;
  logic            tvalid_q;
  logic [ThrW-1:0] thr_q;

  // Pipeline control.
  stg_vec_t v_q;
  stg_vec_t v_d;
  stg_vec_t en;

  // Stage payloads.
  logic [LatW-1:0]  in_lat;
  logic [LngW-1:0]  in_lng;
  logic [AW-1:0]    dlat;
  logic [BW-1:0]    dlng;
  logic [AW-1:0]    sum_lat;
  logic [AW-1:0]    mag_sum;
  logic [AW-1:0]    a_d;
  logic [BW-1:0]    b_d;
  logic [AW-1:0]    a0_q, a1_q, a2_q, a3_q;
  logic [BW-1:0]    b0_q, b1_q, b2_q, b3_q;
  logic [MeanW-1:0] m0_q;
  logic             latp0_q;
  logic             lngp0_q;
  logic [IdxW-1:0]  idx;
  logic [CosW-1:0]  cos_val;
  logic [XpW-1:0]   xprod;
  logic [RW-1:0]    x_q;
  logic [RW-1:0]    y_q;
  logic [RW-1:0]    r_q;
  logic             xfar_q;
  logic             yfar_q;
  logic [61:0]      xx_q;
  logic [61:0]      yy_q;
  logic [61:0]      rr_q;
  logic             far_q;
  logic             arrived;
  dir_e             oct_code;
  dir_e             code_q;

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlat_q   <= '0;
      tlng_q   <= '0;
      tvalid_q <= 1'b0;
      thr_q    <= ThrW'(10);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgTargetLat: begin
          tlat_q <= cfg_data_i[LatW-1:0];
        end
        CfgTargetLng: begin
          tlng_q <= cfg_data_i[LngW-1:0];
        end
        CfgTargetValid: begin
          tvalid_q <= cfg_data_i[0];
        end
        CfgArrivalThr: begin
          thr_q <= cfg_data_i[ThrW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A stage takes new data when it is empty or its successor takes its data.
  always_comb begin
    en[NumStg-1] = !v_q[NumStg-1] || m_axis_tready_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? s_axis_tvalid_i : v_q[0];
    for (int k = 1; k < NumStg; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready_o = en[0];

  // Stage 0: differences, their magnitudes and the mean latitude.
  assign in_lat = s_axis_tdata_i[LatW-1:0];
  assign in_lng = s_axis_tdata_i[LatW+LngW-1:LatW];

  always_comb begin
    dlat    = {tlat_q[LatW-1], tlat_q} - {in_lat[LatW-1], in_lat};
    dlng    = {tlng_q[LngW-1], tlng_q} - {in_lng[LngW-1], in_lng};
    sum_lat = {tlat_q[LatW-1], tlat_q} + {in_lat[LatW-1], in_lat};
    a_d     = dlat[AW-1] ? (~dlat + AW'(1)) : dlat;
    b_d     = dlng[BW-1] ? (~dlng + BW'(1)) : dlng;
    mag_sum = sum_lat[AW-1] ? (~sum_lat + AW'(1)) : sum_lat;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a0_q    <= a_d;
      b0_q    <= b_d;
      m0_q    <= mag_sum[AW-1:1];
      latp0_q <= !dlat[AW-1] && (dlat != '0);
      lngp0_q <= !dlng[BW-1] && (dlng != '0);
    end
  end

  // Stages 1 to 3: magnitudes ride along with the cosine lookup.
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      a1_q <= a0_q;
      b1_q <= b0_q;
    end
    if (en[2]) begin
      a2_q <= a1_q;
      b2_q <= b1_q;
    end
    if (en[3]) begin
      a3_q <= a2_q;
      b3_q <= b2_q;
    end
  end

  wpac_cos_idx #(
    .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
  ) u_cos_idx (
    .clk_i  (clk_i),
    .en_i   (en),
    .mean_i (m0_q),
    .idx_o  (idx)
  );

  wpac_cos_lut #(
    .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
  ) u_cos_lut (
    .clk_i (clk_i),
    .en_i  (en),
    .idx_i (idx),
    .cos_o (cos_val)
  );

  wpac_octant u_octant (
    .clk_i     (clk_i),
    .en_i      (en),
    .a_i       (a0_q),
    .b_i       (b0_q),
    .lat_pos_i (latp0_q),
    .lng_pos_i (lngp0_q),
    .code_o    (oct_code)
  );

  // Stage 4: scaled longitude, latitude in Q8 and radius in Q8.
  assign xprod = XpW'(b3_q) * XpW'(cos_val);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      x_q    <= xprod[RW+6:7];
      xfar_q <= |xprod[XpW-1:RW+7];
      y_q    <= {a3_q[RW-9:0], 8'b0};
      yfar_q <= |a3_q[AW-1:RW-8];
      r_q    <= RW'(thr_q) * RW'(UnitsPerMQ8);
    end
  end

  // Stage 5: squares.
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      xx_q  <= 62'(x_q) * 62'(x_q);
      yy_q  <= 62'(y_q) * 62'(y_q);
      rr_q  <= 62'(r_q) * 62'(r_q);
      far_q <= xfar_q || yfar_q;
    end
  end

  // Stage 6: arrival test and final code.
  assign arrived = !far_q && ((63'(xx_q) + 63'(yy_q)) < 63'(rr_q));

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      if (!tvalid_q) begin
        code_q <= DirNoTarget;
      end else if (arrived) begin
        code_q <= DirArrived;
      end else begin
        code_q <= oct_code;
      end
    end
  end

  assign m_axis_tvalid_o = v_q[NumStg-1];
  assign m_axis_tdata_o  = {4'b0, code_q};

  // An empty output register never blocks the input.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with an empty output register");

  // A full pipeline with a stalled receiver takes no new transaction.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while every stage is full");

  // A fix far beyond any radius is never reported as arrived.
  a_far_not_arrived: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en[6] && v_q[5] && far_q |=> m_axis_tdata_o[3:0] != DirArrived)
    else $error("far fix reported as arrived");

  // A zero radius never gives arrival.
  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en[6] && v_q[5] && (rr_q == '0) |=> m_axis_tdata_o[3:0] != DirArrived)
    else $error("arrival reported with a zero radius");

  // Only defined codes leave the block.
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:0] <= 8'(DirNoTarget))
    else $error("undefined direction code");

endmodule

### test/tb_waypoint_arrival_and_compass_octant.sv
`timescale 1ns / 1ps

module tb_waypoint_arrival_and_compass_octant;
  import wpac_pkg::*;

  localparam int          ClkPeriod    = 10;
  localparam int          CosDepth     = 1024;
  localparam int          NumPhases    = 8;
  localparam int          FixesPerPhase = 85;
  localparam int          NumDirected  = 29;
  localparam longint      TimeLimit    = 2000000;
  localparam logic [63:0] FarLimit     = 64'd1 << 31;
  localparam logic [63:0] UnitsPerMeterQ8 = 64'd23023;

  typedef enum logic {StepFix, StepWrite} step_kind_e;

  // One row of the directed table: a fix or a register write.
  typedef struct packed {
    step_kind_e  kind;
    logic [1:0]  reg_idx;  // register index, write rows only
    logic [31:0] arg0;     // latitude bits, or register data
    logic [31:0] arg1;     // longitude bits
    logic        typed;    // code below is the expected result
    dir_e        code;
  } dir_step_t;

  localparam dir_step_t DirectedSteps [NumDirected] = '{
    // No target loaded after reset.
    '{StepFix, CfgTargetLat, 32'd0, 32'd0, 1'b1, DirNoTarget},
    '{StepFix, CfgTargetLat, 32'd900000000, 32'd1800000000, 1'b1, DirNoTarget},
    '{StepFix, CfgTargetLat, 32'h4000_0000, 32'h8000_0000, 1'b1, DirNoTarget},
    // Target at the origin, default radius of 10 m.
    '{StepWrite, CfgTargetLat, 32'd0, 32'd0, 1'b0, DirN},
    '{StepWrite, CfgTargetLng, 32'd0, 32'd0, 1'b0, DirN},
    '{StepWrite, CfgTargetValid, 32'd1, 32'd0, 1'b0, DirN},
    '{StepFix, CfgTargetLat, 32'd0, 32'd0, 1'b1, DirArrived},
    // One fix in each octant, well outside the radius.
    '{StepFix, CfgTargetLat, -32'sd100000, 32'd0, 1'b1, DirN},
    '{StepFix, CfgTargetLat, -32'sd100000, -32'sd100000, 1'b1, DirNE},
    '{StepFix, CfgTargetLat, 32'd0, -32'sd100000, 1'b1, DirE},
    '{StepFix, CfgTargetLat, 32'd100000, -32'sd100000, 1'b1, DirSE},
    '{StepFix, CfgTargetLat, 32'd100000, 32'd0, 1'b1, DirS},
    '{StepFix, CfgTargetLat, 32'd100000, 32'd100000, 1'b1, DirSW},
    '{StepFix, CfgTargetLat, 32'd0, 32'd100000, 1'b1, DirW},
    '{StepFix, CfgTargetLat, -32'sd100000, 32'd100000, 1'b1, DirNW},
    '{StepFix, CfgTargetLat, 32'd500, 32'd300, 1'b0, DirN},
    '{StepFix, CfgTargetLat, -32'sd900000000, -32'sd1800000000, 1'b0, DirN},
    // Zero radius: the same point is never an arrival.
    '{StepWrite, CfgArrivalThr, 32'd0, 32'd0, 1'b0, DirN},
    '{StepFix, CfgTargetLat, 32'd0, 32'd0, 1'b1, DirN},
    // Target at the far corner, largest radius.
    '{StepWrite, CfgTargetLat, 32'd900000000, 32'd0, 1'b0, DirN},
    '{StepWrite, CfgTargetLng, 32'd1800000000, 32'd0, 1'b0, DirN},
    '{StepWrite, CfgArrivalThr, 32'd65535, 32'd0, 1'b0, DirN},
    '{StepFix, CfgTargetLat, 32'd900000000, 32'd1800000000, 1'b1, DirArrived},
    '{StepFix, CfgTargetLat, -32'sd900000000, -32'sd1800000000, 1'b0, DirN},
    '{StepFix, CfgTargetLat, 32'd899990000, 32'd1800000000, 1'b0, DirN},
    // Mean latitude past the pole.
    '{StepFix, CfgTargetLat, 32'h3FFF_FFFF, 32'd1800000000, 1'b0, DirN},
    // Target unloaded again.
    '{StepWrite, CfgTargetValid, 32'd0, 32'd0, 1'b0, DirN},
    '{StepFix, CfgTargetLat, 32'd0, 32'd0, 1'b1, DirNoTarget},
    '{StepFix, CfgTargetLat, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, DirNoTarget}
  };

  logic            clk_i           = 1'b0;
  logic            rst_ni          = 1'b0;
  logic            cfg_we_i        = 1'b0;
  logic [1:0]      cfg_idx_i       = CfgTargetLat;
  logic [CfgW-1:0] cfg_data_i      = '0;
  logic            s_axis_tvalid_i = 1'b0;
  logic            s_axis_tready_o;
  logic [63:0]     s_axis_tdata_i  = '0;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i = 1'b0;
  logic [7:0]      m_axis_tdata_o;

  // Shadow of the block's configuration, in reset state.
  logic signed [LatW-1:0] tgt_lat   = '0;
  logic signed [LngW-1:0] tgt_lng   = '0;
  logic                   tgt_valid = 1'b0;
  logic [ThrW-1:0]        tgt_thr   = 16'd10;

  logic [CosW-1:0] cos_q15 [CosDepth];
  dir_e            expected_codes [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int code_errors    = 0;
  int fixes_sent     = 0;
  int arrived_seen   = 0;
  int no_target_seen = 0;
  int octant_seen    = 0;

  waypoint_arrival_and_compass_octant #(
    .COS_TABLE_DEPTH(CosDepth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Q1.15 cosine table over a quarter turn, from a nested Taylor series.
  initial begin : fill_cos_table
    longint ang;
    longint ang2;
    longint t;
    longint q;
    for (int i = 0; i < CosDepth; i++) begin
      ang  = longint'(i) * 64'sd1686629713 / CosDepth;
      ang2 = (ang * ang) >>> 30;
      t    = longint'(1) <<< 30;
      // Divisors 132, 90, 56, 30, 12, 2 of the series, innermost first.
      for (int k = 0; k < 6; k++) begin
        if (t < 0) t = 0;
        t = (longint'(1) <<< 30) - ((ang2 * t) >>> 30) / ((12 - 2 * k) * (11 - 2 * k));
      end
      if (t < 0) t = 0;
      q = (t + (longint'(1) <<< 14)) >>> 15;
      if (q > 32767) q = 32767;
      cos_q15[i] = q[CosW-1:0];
    end
  end

  // Direction code that the block must give for one fix.
  function automatic dir_e octant_code_for(logic [LatW-1:0] lat, logic [LngW-1:0] lng);
    longint      tl, tg, pl, pg, dlat, dlng, sum;
    logic [63:0] a, b, m, idx, x, y, r, sa, sb, s;
    logic        arrived;
    if (!tgt_valid) return DirNoTarget;
    tl   = tgt_lat;
    tg   = tgt_lng;
    pl   = $signed(lat);
    pg   = $signed(lng);
    dlat = tl - pl;
    dlng = tg - pg;
    a    = (dlat < 0) ? -dlat : dlat;
    b    = (dlng < 0) ? -dlng : dlng;
    sum  = tl + pl;
    m    = ((sum < 0) ? -sum : sum) >> 1;
    idx  = m * CosDepth / QuarterTurn;
    if (idx >= CosDepth) idx = CosDepth - 1;

    // Equirectangular distance in Q8 units against the radius.
    x       = (b * cos_q15[idx]) >> 7;
    y       = a << 8;
    r       = tgt_thr * UnitsPerMeterQ8;
    arrived = 1'b0;
    if (x < FarLimit && y < FarLimit) arrived = (x * x + y * y) < r * r;
    if (arrived) return DirArrived;
    if (a == 0 && b == 0) return DirN;

    // Octant from the raw differences against tan 22.5 degrees.
    sa = a;
    sb = b;
    while (sa >= FarLimit || sb >= FarLimit) begin
      sa = sa >> 1;
      sb = sb >> 1;
    end
    s = (sa + sb) * (sa + sb);
    if (s < 64'd2 * sa * sa) return (dlat > 0) ? DirN : DirS;
    if (s < 64'd2 * sb * sb) return (dlng > 0) ? DirE : DirW;
    if (dlat > 0) return (dlng > 0) ? DirNE : DirNW;
    return (dlng > 0) ? DirSE : DirSW;
  endfunction

  // Random fix, mostly placed where the interesting decisions happen.
  function automatic void pick_fix(output logic [LatW-1:0] lat, output logic [LngW-1:0] lng);
    longint tl, tg, dl, dg, span;
    int     kind;
    tl   = tgt_lat;
    tg   = tgt_lng;
    kind = $urandom_range(99);
    if (kind < 35) begin
      // Around the arrival radius.
      span = longint'(tgt_thr) * 135 + 20;
      dl   = longint'($urandom_range(32'(2 * span))) - span;
      dg   = longint'($urandom_range(32'(4 * span))) - 2 * span;
    end else if (kind < 55) begin
      // Close to an octant border.
      dl = longint'($urandom_range(1, 1 << 24));
      dg = ((dl * 27146) >>> 16) + longint'($urandom_range(6)) - 3;
      if (dg < 0) dg = 0;
      if ($urandom_range(1)) begin
        span = dl;
        dl   = dg;
        dg   = span;
      end
      if ($urandom_range(1)) dl = -dl;
      if ($urandom_range(1)) dg = -dg;
    end else if (kind < 65) begin
      // On an axis or a diagonal.
      dl = longint'($urandom_range(1, 1 << 26));
      dg = dl;
      case ($urandom_range(2))
        0:       dl = 0;
        1:       dg = 0;
        default: ;
      endcase
      if ($urandom_range(1)) dl = -dl;
      if ($urandom_range(1)) dg = -dg;
    end else if (kind < 90) begin
      // Anywhere in the legal range.
      dl = tl - (longint'($urandom_range(1800000000)) - 900000000);
      dg = tg - (longint'($urandom_range(32'd3600000000)) - 1800000000);
    end else begin
      // Raw bit patterns, legal or not.
      dl = tl - longint'($urandom);
      dg = tg - longint'($urandom);
    end
    lat = LatW'(tl - dl);
    lng = LngW'(tg - dg);
  endfunction

  task automatic report_code_error(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    code_errors++;
  endtask

  // Offer one fix and record its expected code once the transaction completes.
  task automatic send_fix(input logic [LatW-1:0] lat, input logic [LngW-1:0] lng,
                          input logic typed, input dir_e typed_code);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, lng, lat};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_codes.push_back(typed ? typed_code : octant_code_for(lat, lng));
    fixes_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering fixes and wait until every outstanding code has arrived.
  task automatic settle_pipeline();
    s_axis_tvalid_i <= 1'b0;
    while (expected_codes.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgTargetLat:   tgt_lat   = data[LatW-1:0];
      CfgTargetLng:   tgt_lng   = data[LngW-1:0];
      CfgTargetValid: tgt_valid = data[0];
      CfgArrivalThr:  tgt_thr   = data[ThrW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Output stall pattern, changed at the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready_i <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each output transaction with the oldest expected code.
  always @(posedge clk_i) begin : check_codes
    dir_e want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_codes.size() == 0) begin
        report_code_error($sformatf("direction code %0d with no fix outstanding",
                                    m_axis_tdata_o[3:0]));
      end else begin
        want = expected_codes.pop_front();
        if (m_axis_tdata_o[3:0] !== want) begin
          report_code_error($sformatf("direction code %0d, expected %0d (%s)",
                                      m_axis_tdata_o[3:0], want, want.name()));
        end
        if (want == DirArrived) arrived_seen++;
        else if (want == DirNoTarget) no_target_seen++;
        else octant_seen++;
      end
    end
  end

  initial begin : stimulus
    longint          t_lat, t_lng;
    logic            valid;
    logic [ThrW-1:0] thr;
    logic [LatW-1:0] lat;
    logic [LngW-1:0] lng;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table, no flow-control gaps.
    for (int i = 0; i < NumDirected; i++) begin
      if (DirectedSteps[i].kind == StepWrite) begin
        settle_pipeline();
        write_register(DirectedSteps[i].reg_idx, DirectedSteps[i].arg0);
      end else begin
        send_fix(DirectedSteps[i].arg0[LatW-1:0], DirectedSteps[i].arg1,
                 DirectedSteps[i].typed, DirectedSteps[i].code);
      end
    end

    // Random fixes under several targets, radii and flow-control mixes.
    for (int phase = 0; phase < NumPhases; phase++) begin
      settle_pipeline();
      t_lat = longint'($urandom_range(1800000000)) - 900000000;
      t_lng = longint'($urandom_range(32'd3600000000)) - 1800000000;
      valid = 1'b1;
      case (phase)
        0: begin t_lat = 0; t_lng = 0; thr = 16'd10; end
        1: begin t_lat = 900000000; t_lng = 1800000000; thr = 16'hFFFF; end
        2: begin t_lat = -900000000; t_lng = -1800000000; thr = 16'd0; end
        3: thr = ThrW'($urandom_range(1, 200));
        4: begin valid = 1'b0; thr = 16'd50; end
        5: thr = 16'd1;
        6: begin t_lat = 899999000; thr = 16'd5000; end
        default: begin
          t_lat = longint'($urandom);
          t_lng = longint'($urandom);
          thr   = ThrW'($urandom_range(65535));
        end
      endcase
      write_register(CfgTargetLat, CfgW'(t_lat));
      write_register(CfgTargetLng, CfgW'(t_lng));
      write_register(CfgTargetValid, CfgW'(valid));
      write_register(CfgArrivalThr, CfgW'(thr));

      case (phase % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase

      repeat (FixesPerPhase) begin
        pick_fix(lat, lng);
        send_fix(lat, lng, 1'b0, DirN);
      end
    end

    settle_pipeline();
    repeat (NumStg + 4) @(negedge clk_i);

    $display("Sent %0d fixes: a directed table, then %0d targets under four flow-control mixes.",
             fixes_sent, NumPhases);
    $display("Codes checked: %0d arrivals, %0d without target, %0d octants.",
             arrived_seen, no_target_seen, octant_seen);
    if (code_errors == 0 && expected_codes.size() == 0) begin
      $display("** waypoint_arrival_and_compass_octant: PASSED **");
    end else begin
      $display("** waypoint_arrival_and_compass_octant: FAILED **");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #(TimeLimit);
    $display("Timeout with %0d direction codes outstanding.", expected_codes.size());
    $display("** waypoint_arrival_and_compass_octant: FAILED **");
    $finish;
  end

endmodule
